// ----- hw/rtl/cascaded_biquad_equalizer_macros.svh -----
// Assertion macros used by the equalizer sequencer.
`ifndef CASCADED_BIQUAD_EQUALIZER_MACROS_SVH
`define CASCADED_BIQUAD_EQUALIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CBEQ_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CBEQ_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cbeq_pkg.sv -----
// Shared types and constants of the cascaded biquad equalizer.
`default_nettype none

package cbeq_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_BANDS        = 7;
    localparam int DEF_CHANNELS     = 2;
    localparam int DEF_SAMPLE_WIDTH = 24;

    // Field widths of the words on the ports.
    localparam int OP_W    = 2;
    localparam int CH_W    = 1;
    localparam int BAND_W  = 3;
    localparam int IDX_W   = 3;
    localparam int COEF_W  = 32;
    localparam int MASK_W  = 7;
    localparam int STATE_W = 48;

    // Fixed-point layout: coefficients Q6.26, filter state 16 fraction bits.
    localparam int COEF_FRAC  = 26;
    localparam int STATE_FRAC = 16;
    localparam int RND_SHIFT  = COEF_FRAC - STATE_FRAC;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

    // Coefficient slots within one band.
    localparam int N_COEF = 5;
    localparam logic [IDX_W-1:0] CI_B0 = IDX_W'(0);
    localparam logic [IDX_W-1:0] CI_B1 = IDX_W'(1);
    localparam logic [IDX_W-1:0] CI_B2 = IDX_W'(2);
    localparam logic [IDX_W-1:0] CI_A1 = IDX_W'(3);
    localparam logic [IDX_W-1:0] CI_A2 = IDX_W'(4);

    // Operation codes of an input word.
    typedef enum logic [OP_W-1:0] {
        OP_FILTER = 2'd0,
        OP_COEF   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IGNORE = 2'd3
    } op_t;

    // Sequencer states; the band steps are named after the product formed.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MB0,
        ST_MB1,
        ST_MB2,
        ST_MA1,
        ST_MA2,
        ST_WB,
        ST_DONE
    } seq_state_t;

    // Control from the sequencer to the arithmetic datapath.
    typedef struct packed {
        logic       start;
        seq_state_t phase;
    } dp_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cbeq_in_if.sv -----
// Input channel: operation words with valid/ready handshake.
`default_nettype none

interface cbeq_in_if import cbeq_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic [OP_W-1:0]                operation;
    logic [CH_W-1:0]                channel;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [BAND_W-1:0]              band;
    logic [IDX_W-1:0]               coeff_index;
    logic signed [COEF_W-1:0]       coeff_value;

    modport source (
        output valid, operation, channel, sample_in, band, coeff_index, coeff_value,
        input  ready
    );
    modport sink (
        input  valid, operation, channel, sample_in, band, coeff_index, coeff_value,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/cbeq_out_if.sv -----
// Output channel: filtered sample words with valid/ready handshake.
`default_nettype none

interface cbeq_out_if import cbeq_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic [CH_W-1:0]                channel_out;
    logic                           clipped;

    modport source (
        output valid, sample_out, channel_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, sample_out, channel_out, clipped,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/cbeq_cfg_if.sv -----
// Configuration channel: band enable mask words with valid/ready handshake.
`default_nettype none

interface cbeq_cfg_if import cbeq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] band_enable_mask;

    modport source (
        output valid, band_enable_mask,
        input  ready
    );
    modport sink (
        input  valid, band_enable_mask,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/cbeq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module cbeq_ram import cbeq_pkg::*; #(
    parameter int WIDTH = COEF_W,
    parameter int DEPTH = DEF_BANDS * N_COEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cbeq_vmem.sv -----
// RAM with one valid bit per entry, so that unwritten entries read as a default.
`default_nettype none

module cbeq_vmem import cbeq_pkg::*; #(
    parameter int WIDTH = COEF_W,
    parameter int DEPTH = DEF_BANDS * N_COEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clr,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    input  wire logic [WIDTH-1:0] rdflt,
    output logic      [WIDTH-1:0] rdata
);

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic             hit_reg;
    logic [WIDTH-1:0] dflt_reg;
    logic [WIDTH-1:0] ram_rdata;

    cbeq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // A clear drops every valid bit at once; a write marks its entry.
    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (re)
            begin
                hit_reg <= valid_reg[raddr];
            end
        end
    end

    // The default travels alongside the read so it lines up with the RAM data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            dflt_reg <= rdflt;
        end
    end

    assign rdata = hit_reg ? ram_rdata : dflt_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cbeq_dp.sv -----
// Arithmetic datapath: one shared multiplier walks the five products of a band.
`default_nettype none

module cbeq_dp import cbeq_pkg::*; #(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  wire logic                           clk,
    input  wire dp_ctrl_t                       ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic [COEF_W-1:0]              coef,
    input  wire logic [2*STATE_W-1:0]           state_rd,
    output logic      [2*STATE_W-1:0]           state_wr,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_res,
    output logic                                clip
);

    // Product, rounded product, accumulator and band output widths.
    localparam int P_W = COEF_W + SAMPLE_WIDTH;
    localparam int R_W = P_W - RND_SHIFT;
    localparam int A_W = ((R_W > STATE_W) ? R_W : STATE_W) + 2;
    localparam int Y_W = A_W - STATE_FRAC;

    localparam logic signed [P_W-1:0] RND_HALF = P_W'(2 ** (RND_SHIFT - 1));
    localparam logic signed [A_W-1:0] ACC_HALF = A_W'(2 ** (STATE_FRAC - 1));
    localparam logic signed [Y_W-1:0] Y_MAX =
        {{(Y_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [A_W-1:0] S_MAX =
        {{(A_W - STATE_W + 1){1'b0}}, {(STATE_W - 1){1'b1}}};
    localparam logic signed [A_W-1:0] S_MIN = ~S_MAX;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [STATE_W-1:0]      z0_reg;
    logic signed [STATE_W-1:0]      z1_reg;
    logic signed [P_W-1:0]          prod_reg;
    logic signed [A_W-1:0]          t0_reg;
    logic signed [A_W-1:0]          t1_reg;
    logic signed [STATE_W-1:0]      nz0_reg;
    logic                           clip_reg;

    logic signed [SAMPLE_WIDTH-1:0] mul_b;
    logic signed [P_W-1:0]          prod_next;
    logic signed [P_W-1:0]          prod_rnd;
    logic signed [R_W-1:0]          r_val;
    logic signed [A_W-1:0]          r_ext;
    logic signed [A_W-1:0]          acc_rnd;
    logic signed [Y_W-1:0]          y_sh;
    logic signed [SAMPLE_WIDTH-1:0] y_next;
    logic                           y_clip;
    logic signed [A_W-1:0]          t0_next;
    logic signed [A_W-1:0]          diff;
    logic signed [STATE_W-1:0]      nz_sat;

    // The feedback products take the band output, the others the band input.
    assign mul_b     = (ctrl.phase == ST_MA1 || ctrl.phase == ST_MA2) ? y_reg : x_reg;
    assign prod_next = $signed(coef) * mul_b;

    // Round the registered product to the state's 16 fraction bits.
    assign prod_rnd = prod_reg + RND_HALF;
    assign r_val    = $signed(prod_rnd[P_W-1:RND_SHIFT]);
    assign r_ext    = A_W'(r_val);

    // Band output: b0*x + z0, rounded to an integer and saturated.
    always_comb
    begin
        acc_rnd = r_ext + A_W'(z0_reg) + ACC_HALF;
        y_sh    = $signed(acc_rnd[A_W-1:STATE_FRAC]);
        y_clip  = 1'b0;
        if (y_sh > Y_MAX)
        begin
            y_next = Y_MAX[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end
        else if (y_sh < Y_MIN)
        begin
            y_next = Y_MIN[SAMPLE_WIDTH-1:0];
            y_clip = 1'b1;
        end
        else
        begin
            y_next = y_sh[SAMPLE_WIDTH-1:0];
        end
    end

    assign t0_next = r_ext + A_W'(z1_reg);

    // New state: feed-forward part minus the feedback product, held to 48 bits.
    always_comb
    begin
        diff = ((ctrl.phase == ST_MA2) ? t0_reg : t1_reg) - r_ext;
        if (diff > S_MAX)
        begin
            nz_sat = S_MAX[STATE_W-1:0];
        end
        else if (diff < S_MIN)
        begin
            nz_sat = S_MIN[STATE_W-1:0];
        end
        else
        begin
            nz_sat = diff[STATE_W-1:0];
        end
    end

    // One action per band step; the multiplier is registered every cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.start)
        begin
            x_reg    <= sample_in;
            clip_reg <= 1'b0;
        end
        case (ctrl.phase)
            ST_MB0:
            begin
                z0_reg <= $signed(state_rd[2*STATE_W-1:STATE_W]);
                z1_reg <= $signed(state_rd[STATE_W-1:0]);
            end
            ST_MB1:
            begin
                y_reg    <= y_next;
                clip_reg <= clip_reg | y_clip;
            end
            ST_MB2:
            begin
                t0_reg <= t0_next;
            end
            ST_MA1:
            begin
                t1_reg <= r_ext;
            end
            ST_MA2:
            begin
                nz0_reg <= nz_sat;
            end
            ST_WB:
            begin
                x_reg <= y_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign state_wr   = {nz0_reg, nz_sat};
    assign sample_res = x_reg;
    assign clip       = clip_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cbeq_seq.sv -----
// Sequencer: handshakes, mask register, band walk and memory addressing.
`default_nettype none
`include "cascaded_biquad_equalizer_macros.svh"

module cbeq_seq import cbeq_pkg::*; #(
    parameter int BANDS        = DEF_BANDS,
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    localparam int CA_W = (BANDS * N_COEF > 1) ? $clog2(BANDS * N_COEF) : 1,
    localparam int SA_W = (CHANNELS * BANDS > 1) ? $clog2(CHANNELS * BANDS) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cbeq_in_if.sink                             item,
    cbeq_out_if.source                          result,
    cbeq_cfg_if.sink                            cfg,
    output logic                                coef_we,
    output logic [CA_W-1:0]                     coef_waddr,
    output logic                                coef_re,
    output logic [CA_W-1:0]                     coef_raddr,
    output logic [COEF_W-1:0]                   coef_rdflt,
    output logic                                state_clr,
    output logic                                state_we,
    output logic                                state_re,
    output logic [SA_W-1:0]                     state_addr,
    output dp_ctrl_t                            dp_ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_res,
    input  wire logic                           clip
);

    localparam int BW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    seq_state_t                     state_reg;
    seq_state_t                     state_next;
    logic [BW-1:0]                  band_reg;
    logic [BW-1:0]                  band_next;
    logic [MASK_W-1:0]              mask_reg;
    logic [CHW-1:0]                 ch_reg;
    logic [CH_W-1:0]                ch_field_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic [CH_W-1:0]                out_ch_reg;
    logic                           out_clip_reg;

    logic                           accept;
    logic                           start;
    logic                           out_load;
    logic                           last_band;
    logic [BANDS-1:0]               band_en;
    logic [IDX_W-1:0]               slot;
    logic                           coef_addr_ok;

    // Bands beyond the mask width are never switched in.
    for (genvar b = 0; b < BANDS; b++)
    begin : g_en
        if (b < MASK_W)
        begin : g_on
            assign band_en[b] = mask_reg[b];
        end
        else
        begin : g_off
            assign band_en[b] = 1'b0;
        end
    end

    // Input handshake: one operation word at a time.
    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign start      = accept && (item.operation == OP_FILTER);
    assign last_band  = (band_reg == BW'(BANDS - 1));

    // Coefficient writes to slots outside the store are dropped.
    assign coef_addr_ok = (item.band < BANDS) && (item.coeff_index < N_COEF);
    assign coef_we      = accept && (item.operation == OP_COEF) && coef_addr_ok;
    assign coef_waddr   = CA_W'(item.band * N_COEF + item.coeff_index);
    assign state_clr    = accept && (item.operation == OP_CLEAR);

    // The configuration word is always taken.
    assign cfg.ready = 1'b1;

    // Next state, band counter and memory read controls.
    always_comb
    begin
        state_next = state_reg;
        band_next  = band_reg;
        out_load   = 1'b0;
        coef_re    = 1'b0;
        slot       = CI_B0;
        state_re   = 1'b0;
        state_we   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    band_next  = '0;
                end
            end
            ST_SCAN:
            begin
                if (band_en[band_reg])
                begin
                    state_next = ST_READ;
                end
                else if (last_band)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    band_next = band_reg + BW'(1);
                end
            end
            ST_READ:
            begin
                coef_re    = 1'b1;
                slot       = CI_B0;
                state_re   = 1'b1;
                state_next = ST_MB0;
            end
            ST_MB0:
            begin
                coef_re    = 1'b1;
                slot       = CI_B1;
                state_next = ST_MB1;
            end
            ST_MB1:
            begin
                coef_re    = 1'b1;
                slot       = CI_B2;
                state_next = ST_MB2;
            end
            ST_MB2:
            begin
                coef_re    = 1'b1;
                slot       = CI_A1;
                state_next = ST_MA1;
            end
            ST_MA1:
            begin
                coef_re    = 1'b1;
                slot       = CI_A2;
                state_next = ST_MA2;
            end
            ST_MA2:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                state_we = 1'b1;
                if (last_band)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    band_next  = band_reg + BW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An unwritten b0 reads as unity, every other unwritten slot as zero.
    assign coef_raddr = CA_W'(band_reg * N_COEF + slot);
    assign coef_rdflt = (slot == CI_B0) ? COEF_ONE : '0;
    assign state_addr = SA_W'(ch_reg * BANDS + band_reg);

    assign dp_ctrl.start = start;
    assign dp_ctrl.phase = state_reg;

    // Output register: holds a finished word until the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_reg      <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            band_reg      <= band_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mask_reg <= cfg.band_enable_mask;
            end
        end
    end

    // Channels beyond the state array share the last channel's state.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ch_field_reg <= item.channel;
            ch_reg       <= (item.channel < CHANNELS) ? CHW'(item.channel)
                                                      : CHW'(CHANNELS - 1);
        end
        if (out_load)
        begin
            out_sample_reg <= sample_res;
            out_ch_reg     <= ch_field_reg;
            out_clip_reg   <= clip;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.sample_out  = out_sample_reg;
    assign result.channel_out = out_ch_reg;
    assign result.clipped     = out_clip_reg;

    // A filter word always starts with the band scan.
    `CBEQ_ASSERT_NXT(a_start_scan, clk, rst_n, start, state_reg == ST_SCAN,
        "filter word did not start the band scan")
    // Coefficient writes never meet a coefficient read.
    `CBEQ_ASSERT_IMP(a_coef_port, clk, rst_n, coef_we, !coef_re,
        "coefficient write during a band walk")
    // The finished word waits while the output register is still occupied.
    `CBEQ_ASSERT_NXT(a_done_hold, clk, rst_n,
        state_reg == ST_DONE && out_valid_reg && !result.ready, state_reg == ST_DONE,
        "result overwrote a word not yet taken")
    // After a write-back the walk goes on to the next band or finishes.
    `CBEQ_ASSERT_NXT(a_wb_next, clk, rst_n, state_reg == ST_WB,
        state_reg == ST_SCAN || state_reg == ST_DONE,
        "band write-back followed by an unexpected step")

endmodule

`default_nettype wire

// ----- hw/rtl/cascaded_biquad_equalizer.sv -----
// Top level of the cascaded biquad equalizer: sequencer, datapath and two stores.
// Filter word: each band takes a scan step, an enabled band seven more (read, five products,
// write-back); the result then waits in ST_DONE until the output register is free.
// The next word is taken from the cycle after, once the result sits in the output register.
// Coefficient and clear words give no result and leave the sequencer idle.
// Reset: mask zero, each band reads b0 = 1.0 and all else zero, all state zero, no sweep needed.
`default_nettype none

module cascaded_biquad_equalizer import cbeq_pkg::*; #(
    parameter int BANDS        = DEF_BANDS,
    parameter int CHANNELS     = DEF_CHANNELS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cbeq_in_if.sink    item,
    cbeq_out_if.source result,
    cbeq_cfg_if.sink   cfg
);

    localparam int CA_W = (BANDS * N_COEF > 1) ? $clog2(BANDS * N_COEF) : 1;
    localparam int SA_W = (CHANNELS * BANDS > 1) ? $clog2(CHANNELS * BANDS) : 1;

    logic                           coef_we;
    logic [CA_W-1:0]                coef_waddr;
    logic                           coef_re;
    logic [CA_W-1:0]                coef_raddr;
    logic [COEF_W-1:0]              coef_rdflt;
    logic [COEF_W-1:0]              coef_rdata;
    logic                           state_clr;
    logic                           state_we;
    logic                           state_re;
    logic [SA_W-1:0]                state_addr;
    logic [2*STATE_W-1:0]           state_rdata;
    logic [2*STATE_W-1:0]           state_wdata;
    dp_ctrl_t                       dp_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] sample_res;
    logic                           clip;

    // Control of the whole block.
    cbeq_seq #(
        .BANDS        (BANDS),
        .CHANNELS     (CHANNELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_re    (coef_re),
        .coef_raddr (coef_raddr),
        .coef_rdflt (coef_rdflt),
        .state_clr  (state_clr),
        .state_we   (state_we),
        .state_re   (state_re),
        .state_addr (state_addr),
        .dp_ctrl    (dp_ctrl),
        .sample_res (sample_res),
        .clip       (clip)
    );

    // Coefficient store: five Q6.26 words per band.
    cbeq_vmem #(
        .WIDTH (COEF_W),
        .DEPTH (BANDS * N_COEF)
    ) u_coef_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (1'b0),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (item.coeff_value),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdflt (coef_rdflt),
        .rdata (coef_rdata)
    );

    // Filter state store: one row of z0 and z1 per channel and band.
    cbeq_vmem #(
        .WIDTH (2 * STATE_W),
        .DEPTH (CHANNELS * BANDS)
    ) u_state_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (state_clr),
        .we    (state_we),
        .waddr (state_addr),
        .wdata (state_wdata),
        .re    (state_re),
        .raddr (state_addr),
        .rdflt ('0),
        .rdata (state_rdata)
    );

    // Multiply, round and saturate.
    cbeq_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .ctrl       (dp_ctrl),
        .sample_in  (item.sample_in),
        .coef       (coef_rdata),
        .state_rd   (state_rdata),
        .state_wr   (state_wdata),
        .sample_res (sample_res),
        .clip       (clip)
    );

endmodule

`default_nettype wire
